// File: hw/rtl/go_to_pose_velocity_controller_core_assert.svh
// ----------------------------------------------------------------------------
// go to pose controller assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef GO_TO_POSE_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_POSE_VELOCITY_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define GTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// types, constants and helpers of the go to pose velocity controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned ASH           = 44 - FRACTION_BITS;

  localparam int unsigned EW   = 25;
  localparam int unsigned XW   = 36;
  localparam int unsigned ZW   = 34;
  localparam int unsigned BW   = 28;
  localparam int unsigned NW   = 57;
  localparam int unsigned SW   = 64;
  localparam int unsigned RW   = 32;
  localparam int unsigned REMW = 36;
  localparam int unsigned QW   = 24;
  localparam int unsigned EMW  = 47;
  localparam int unsigned LW   = 23;
  localparam int unsigned TW   = 23;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [30:0] PI_Q29       = 31'd1686629713;
  localparam logic [28:0] DIV10_M      = 29'd429496730;

  localparam longint unsigned NORM_THR =
    (64'd1 << (2 * FRACTION_BITS)) / 64'd1000000000000;
  localparam longint unsigned SLOW_L2 =
    ((64'd1 << (2 * FRACTION_BITS)) + 64'd9999) / 64'd10000;

  localparam logic [2:0] REG_POS_TOL  = 3'd0;
  localparam logic [2:0] REG_ANG_TOL  = 3'd1;
  localparam logic [2:0] REG_MAX_X    = 3'd2;
  localparam logic [2:0] REG_MAX_Y    = 3'd3;
  localparam logic [2:0] REG_MAX_TURN = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;

  localparam logic [15:0] POS_TOL_RST  = 16'd655;
  localparam logic [14:0] ANG_TOL_RST  = 15'd182;
  localparam logic [22:0] MAX_X_RST    = 23'd65536;
  localparam logic [22:0] MAX_Y_RST    = 23'd65536;
  localparam logic [22:0] MAX_TURN_RST = 23'd262144;

  typedef struct packed {
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [15:0] robot_heading;
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
    logic signed [15:0] goal_heading;
  } in_t;

  typedef struct packed {
    logic               valid;
    logic               arrived;
    logic               near;
    logic               big;
    logic               e_neg;
    logic [EMW-1:0]     em;
    logic signed [BW-1:0] bx;
    logic signed [BW-1:0] by;
    logic [NW-1:0]      nx;
    logic [NW-1:0]      ny;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0]   v;
    logic [RW-1:0]   root;
    logic [REMW-1:0] rem;
  } sqrt_t;

  typedef struct packed {
    logic [RW-1:0] d;
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

  typedef struct packed {
    logic               arrived;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] tr;
  } res_t;

  function automatic logic [29:0] atan_of(input int unsigned idx);
    logic [29:0] a;
    case (idx)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458907;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [23:0] sat(input logic signed [31:0] v,
                                             input logic [22:0] lim);
    logic signed [31:0] l;
    logic signed [31:0] nl;
    logic signed [31:0] r;
    l  = $signed({9'd0, lim});
    nl = -l;
    if (v > l) begin
      r = l;
    end else if (v < nl) begin
      r = nl;
    end else begin
      r = v;
    end
    return r[23:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gtp_cordic_cell.sv
// ----------------------------------------------------------------------------
// gtp_cordic_cell
// one rotation stage of the body frame cordic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtp_cordic_cell import gtp_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cordic_t c_in,
  input  side_t   s_in,
  output cordic_t c_out,
  output side_t   s_out
);

  cordic_t c_r;
  cordic_t c_nxt;
  side_t   s_r;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;

  always_comb begin
    xs = $signed(c_in.x) >>> STAGE;
    ys = $signed(c_in.y) >>> STAGE;
    at = $signed({{(ZW-30){1'b0}}, atan_of(STAGE)});
    if (!c_in.z[ZW-1]) begin
      c_nxt.x = c_in.x - ys;
      c_nxt.y = c_in.y + xs;
      c_nxt.z = c_in.z - at;
    end else begin
      c_nxt.x = c_in.x + ys;
      c_nxt.y = c_in.y - xs;
      c_nxt.z = c_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (en) begin
      s_r <= s_in;
    end
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;
  assign s_out = s_r;

endmodule

`default_nettype wire

// File: hw/rtl/gtp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gtp_sqrt_cell
// one root bit of the digit by digit square root of the body error norm
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtp_sqrt_cell import gtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  sqrt_t q_in,
  input  side_t s_in,
  output sqrt_t q_out,
  output side_t s_out
);

  sqrt_t q_r;
  sqrt_t q_nxt;
  side_t s_r;
  logic [REMW-1:0] r2;
  logic [REMW-1:0] trial;
  logic            ge;

  always_comb begin
    r2    = {q_in.rem[REMW-3:0], q_in.v[SW-1:SW-2]};
    trial = {2'b00, q_in.root, 2'b01};
    ge    = (r2 >= trial);
    q_nxt.rem  = ge ? (r2 - trial) : r2;
    q_nxt.root = {q_in.root[RW-2:0], ge};
    q_nxt.v    = {q_in.v[SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (en) begin
      s_r <= s_in;
    end
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;
  assign s_out = s_r;

endmodule

`default_nettype wire

// File: hw/rtl/gtp_div_cell.sv
// ----------------------------------------------------------------------------
// gtp_div_cell
// one quotient bit of the two restoring speed dividers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtp_div_cell import gtp_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  div_t  d_in,
  input  side_t s_in,
  output div_t  d_out,
  output side_t s_out
);

  div_t  d_r;
  div_t  d_nxt;
  side_t s_r;
  logic [NW-1:0] dd;
  logic          gx;
  logic          gy;

  always_comb begin
    dd    = {{(NW-RW){1'b0}}, d_in.d} << BIT;
    gx    = (d_in.rx >= dd);
    gy    = (d_in.ry >= dd);
    d_nxt = d_in;
    if (gx) begin
      d_nxt.rx     = d_in.rx - dd;
      d_nxt.qx[BIT] = 1'b1;
    end
    if (gy) begin
      d_nxt.ry     = d_in.ry - dd;
      d_nxt.qy[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (en) begin
      s_r <= s_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
  assign s_out = s_r;

endmodule

`default_nettype wire

// File: hw/rtl/go_to_pose_velocity_controller_core.sv
// ----------------------------------------------------------------------------
// go_to_pose_velocity_controller_core
// holonomic go to pose controller: pose error, cordic body rotation,
// proportional or constant speed law, saturated velocity request
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in       in         in_valid / in_stall          robot pose, goal pose
//  out      out        out_valid / out_stall        arrived, body_vx/vy, turn
//  cfg      in         psel penable pwrite pready   six control registers
//
//  one request per cycle while the skid register is empty and in_stall is low
//  pipeline depth set by the cordic, square root and divider cell chains
//  synchronous active low reset, no clearing pass
//  a stalled output parks one result in a skid register, then in_stall rises
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_to_pose_velocity_controller_core import gtp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_robot_x,
  input  logic signed [23:0] in_robot_y,
  input  logic signed [15:0] in_robot_heading,
  input  logic signed [23:0] in_goal_x,
  input  logic signed [23:0] in_goal_y,
  input  logic signed [15:0] in_goal_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_arrived,
  output logic signed [23:0] out_body_vx,
  output logic signed [23:0] out_body_vy,
  output logic signed [23:0] out_turn_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // the atan table has 24 entries
  localparam int unsigned CORDIC_RUN = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

  // control registers
  logic [15:0] pos_tol_r;
  logic [14:0] ang_tol_r;
  logic [22:0] max_x_r;
  logic [22:0] max_y_r;
  logic [22:0] max_t_r;
  logic        mode_r;
  logic [2:0]  ridx;
  logic        wr;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_r <= POS_TOL_RST;
      ang_tol_r <= ANG_TOL_RST;
      max_x_r   <= MAX_X_RST;
      max_y_r   <= MAX_Y_RST;
      max_t_r   <= MAX_TURN_RST;
      mode_r    <= 1'b0;
    end else if (wr) begin
      unique case (ridx)
        REG_POS_TOL:  pos_tol_r <= pwdata[15:0];
        REG_ANG_TOL:  ang_tol_r <= pwdata[14:0];
        REG_MAX_X:    max_x_r   <= pwdata[22:0];
        REG_MAX_Y:    max_y_r   <= pwdata[22:0];
        REG_MAX_TURN: max_t_r   <= pwdata[22:0];
        REG_MODE:     mode_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_POS_TOL:  prdata = {16'd0, pos_tol_r};
      REG_ANG_TOL:  prdata = {17'd0, ang_tol_r};
      REG_MAX_X:    prdata = {9'd0, max_x_r};
      REG_MAX_Y:    prdata = {9'd0, max_y_r};
      REG_MAX_TURN: prdata = {9'd0, max_t_r};
      REG_MODE:     prdata = {31'd0, mode_r};
      default:      prdata = 32'd0;
    endcase
  end

  // pipeline enable and output skid
  logic en;
  logic skid_full_r;
  logic out_valid_r;
  res_t out_r;
  res_t skid_r;
  res_t tail;
  logic tail_v;
  logic take;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  // input register
  logic v0_r;
  in_t  in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
    if (en) begin
      in_r.robot_x          <= in_robot_x;
      in_r.robot_y          <= in_robot_y;
      in_r.robot_heading    <= in_robot_heading;
      in_r.goal_x           <= in_goal_x;
      in_r.goal_y           <= in_goal_y;
      in_r.goal_heading     <= in_goal_heading;
    end
  end

  // world error
  logic                  v1_r;
  logic signed [EW-1:0]  ex1_r;
  logic signed [EW-1:0]  ey1_r;
  logic signed [15:0]    e1_r;
  logic signed [15:0]    rh1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
    if (en) begin
      ex1_r <= {in_r.goal_x[23], in_r.goal_x} - {in_r.robot_x[23], in_r.robot_x};
      ey1_r <= {in_r.goal_y[23], in_r.goal_y} - {in_r.robot_y[23], in_r.robot_y};
      e1_r  <= in_r.goal_heading - in_r.robot_heading;
      rh1_r <= in_r.robot_heading;
    end
  end

  // products
  logic                  v2_r;
  logic signed [49:0]    exx2_r;
  logic signed [49:0]    eyy2_r;
  logic signed [54:0]    px2_r;
  logic signed [54:0]    py2_r;
  logic [31:0]           tolsq2_r;
  logic [15:0]           ae2_r;
  logic                  eneg2_r;
  logic [EMW-1:0]        em2_r;
  logic [31:0]           z2_r;
  logic [15:0]           ae1;
  logic [15:0]           nrh1;
  logic signed [15:0]    ne1;

  always_comb begin
    ne1  = -e1_r;
    ae1  = e1_r[15] ? ne1 : e1_r;
    nrh1 = -rh1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      exx2_r   <= ex1_r * ex1_r;
      eyy2_r   <= ey1_r * ey1_r;
      px2_r    <= ex1_r * $signed({1'b0, INV_GAIN_Q30});
      py2_r    <= ey1_r * $signed({1'b0, INV_GAIN_Q30});
      tolsq2_r <= pos_tol_r * pos_tol_r;
      ae2_r    <= ae1;
      eneg2_r  <= e1_r[15];
      em2_r    <= ae1 * PI_Q29;
      z2_r     <= {nrh1, 16'h0000};
    end
  end

  // reach test, scaling and pre-rotation
  cordic_t c3_r;
  side_t   side3_r;
  cordic_t c3_nxt;
  side_t   side3_nxt;
  logic [50:0]        d2;
  logic signed [54:0] pxr;
  logic signed [54:0] pyr;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic               flip;
  logic [31:0]        zz;

  always_comb begin
    d2   = 51'(exx2_r) + 51'(eyy2_r);
    pxr  = px2_r + (55'sd1 <<< 21);
    pyr  = py2_r + (55'sd1 <<< 21);
    x0   = {{(XW-33){pxr[54]}}, pxr[54:22]};
    y0   = {{(XW-33){pyr[54]}}, pyr[54:22]};
    flip = z2_r[31] ^ z2_r[30];
    zz   = {z2_r[31] ^ flip, z2_r[30:0]};
    c3_nxt.x = flip ? -x0 : x0;
    c3_nxt.y = flip ? -y0 : y0;
    c3_nxt.z = {{(ZW-32){zz[31]}}, zz};
    side3_nxt         = '0;
    side3_nxt.valid   = v2_r;
    side3_nxt.near    = (d2 < 51'(tolsq2_r));
    side3_nxt.arrived = side3_nxt.near && (ae2_r < {1'b0, ang_tol_r});
    side3_nxt.e_neg   = eneg2_r;
    side3_nxt.em      = em2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r <= '0;
    end else if (en) begin
      side3_r <= side3_nxt;
    end
    if (en) begin
      c3_r <= c3_nxt;
    end
  end

  // cordic chain
  cordic_t cw [CORDIC_RUN+1];
  side_t   cs [CORDIC_RUN+1];

  assign cw[0] = c3_r;
  assign cs[0] = side3_r;

  for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_cordic
    gtp_cordic_cell #(.STAGE(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .c_in  (cw[i]),
      .s_in  (cs[i]),
      .c_out (cw[i+1]),
      .s_out (cs[i+1])
    );
  end

  // body error
  side_t side4_r;
  side_t side4_nxt;
  logic signed [XW-1:0] xa;
  logic signed [XW-1:0] ya;

  always_comb begin
    xa = cw[CORDIC_RUN].x + XW'(128);
    ya = cw[CORDIC_RUN].y + XW'(128);
    side4_nxt    = cs[CORDIC_RUN];
    side4_nxt.bx = xa[XW-1:8];
    side4_nxt.by = ya[XW-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r <= '0;
    end else if (en) begin
      side4_r <= side4_nxt;
    end
  end

  // norm squares and speed numerators
  side_t side5_r;
  side_t side5_nxt;
  logic signed [2*BW-1:0] bxx5_r;
  logic signed [2*BW-1:0] byy5_r;
  logic [BW-1:0] abx;
  logic [BW-1:0] aby;
  logic [BW+22:0] nxp;
  logic [BW+22:0] nyp;

  always_comb begin
    abx = side4_r.bx[BW-1] ? BW'(-side4_r.bx) : side4_r.bx;
    aby = side4_r.by[BW-1] ? BW'(-side4_r.by) : side4_r.by;
    nxp = abx * max_x_r;
    nyp = aby * max_y_r;
    side5_nxt    = side4_r;
    side5_nxt.nx = {nxp, 6'b000000};
    side5_nxt.ny = {nyp, 6'b000000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r <= '0;
    end else if (en) begin
      side5_r <= side5_nxt;
    end
    if (en) begin
      bxx5_r  <= side4_r.bx * side4_r.bx;
      byy5_r  <= side4_r.by * side4_r.by;
    end
  end

  // square root input
  sqrt_t sq6_r;
  side_t side6_r;
  sqrt_t sq6_nxt;
  side_t side6_nxt;
  logic [2*BW:0] n2;

  always_comb begin
    n2           = (2*BW+1)'(bxx5_r) + (2*BW+1)'(byy5_r);
    sq6_nxt.v    = {n2[51:0], 12'h000};
    sq6_nxt.root = '0;
    sq6_nxt.rem  = '0;
    side6_nxt     = side5_r;
    side6_nxt.big = (n2 > (2*BW+1)'(NORM_THR));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side6_r <= '0;
    end else if (en) begin
      side6_r <= side6_nxt;
    end
    if (en) begin
      sq6_r <= sq6_nxt;
    end
  end

  // square root chain
  sqrt_t sw [RW+1];
  side_t ss [RW+1];

  assign sw[0] = sq6_r;
  assign ss[0] = side6_r;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    gtp_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .q_in  (sw[i]),
      .s_in  (ss[i]),
      .q_out (sw[i+1]),
      .s_out (ss[i+1])
    );
  end

  // divider input with half divisor for rounding
  div_t  dv7_r;
  side_t side7_r;
  div_t  dv7_nxt;

  always_comb begin
    dv7_nxt.d  = sw[RW].root;
    dv7_nxt.rx = ss[RW].nx + NW'(sw[RW].root >> 1);
    dv7_nxt.ry = ss[RW].ny + NW'(sw[RW].root >> 1);
    dv7_nxt.qx = '0;
    dv7_nxt.qy = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side7_r <= '0;
    end else if (en) begin
      side7_r <= ss[RW];
    end
    if (en) begin
      dv7_r <= dv7_nxt;
    end
  end

  // divider chain
  div_t  dw [QW+1];
  side_t ds [QW+1];

  assign dw[0] = dv7_r;
  assign ds[0] = side7_r;

  for (genvar i = 0; i < QW; i++) begin : g_div
    gtp_div_cell #(.BIT(QW-1-i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dw[i]),
      .s_in  (ds[i]),
      .d_out (dw[i+1]),
      .s_out (ds[i+1])
    );
  end

  // linear velocity per mode
  side_t              side8_r;
  logic signed [23:0] vx8_r;
  logic signed [23:0] vy8_r;
  logic signed [31:0] qxs;
  logic signed [31:0] qys;
  logic signed [31:0] bx2;
  logic signed [31:0] by2;
  logic signed [23:0] vx8_nxt;
  logic signed [23:0] vy8_nxt;
  side_t              s8;

  always_comb begin
    s8  = ds[QW];
    qxs = s8.bx[BW-1] ? -$signed({8'd0, dw[QW].qx}) : $signed({8'd0, dw[QW].qx});
    qys = s8.by[BW-1] ? -$signed({8'd0, dw[QW].qy}) : $signed({8'd0, dw[QW].qy});
    bx2 = 32'(s8.bx) <<< 1;
    by2 = 32'(s8.by) <<< 1;
    if (mode_r) begin
      vx8_nxt = s8.big ? sat(qxs, max_x_r) : 24'sd0;
      vy8_nxt = s8.big ? sat(qys, max_y_r) : 24'sd0;
    end else begin
      vx8_nxt = sat(bx2, max_x_r);
      vy8_nxt = sat(by2, max_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side8_r <= '0;
    end else if (en) begin
      side8_r <= s8;
    end
    if (en) begin
      vx8_r   <= vx8_nxt;
      vy8_r   <= vy8_nxt;
    end
  end

  // speed squares
  side_t              side9_r;
  logic signed [23:0] vx9_r;
  logic signed [23:0] vy9_r;
  logic signed [47:0] vxx9_r;
  logic signed [47:0] vyy9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side9_r <= '0;
    end else if (en) begin
      side9_r <= side8_r;
    end
    if (en) begin
      vx9_r   <= vx8_r;
      vy9_r   <= vy8_r;
      vxx9_r  <= vx8_r * vx8_r;
      vyy9_r  <= vy8_r * vy8_r;
    end
  end

  // turn gain and rounding
  side_t              side10_r;
  logic signed [23:0] vx10_r;
  logic signed [23:0] vy10_r;
  logic [TW-1:0]      t1_10_r;
  logic [TW-1:0]      t0_10_r;
  logic [48:0]        l2;
  logic               slow;
  logic [EMW+3:0]     em10;
  logic [EMW+3:0]     tsel;
  logic [EMW+3:0]     t1w;
  logic [EMW+3:0]     t0w;

  always_comb begin
    l2   = 49'(vxx9_r) + 49'(vyy9_r);
    slow = (l2 < 49'(SLOW_L2));
    em10 = ((EMW+4)'(side9_r.em) << 3) + ((EMW+4)'(side9_r.em) << 1);
    tsel = slow ? em10 : (EMW+4)'(side9_r.em);
    t1w  = (tsel + ((EMW+4)'(1) << (ASH-1))) >> ASH;
    t0w  = ((EMW+4)'(side9_r.em) + ((EMW+4)'(5) << ASH)) >> ASH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side10_r <= '0;
    end else if (en) begin
      side10_r <= side9_r;
    end
    if (en) begin
      vx10_r   <= vx9_r;
      vy10_r   <= vy9_r;
      t1_10_r  <= t1w[TW-1:0];
      t0_10_r  <= t0w[TW-1:0];
    end
  end

  // divide by ten through reciprocal
  side_t              side11_r;
  logic signed [23:0] vx11_r;
  logic signed [23:0] vy11_r;
  logic [TW-1:0]      t1_11_r;
  logic [TW+28:0]     p11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side11_r <= '0;
    end else if (en) begin
      side11_r <= side10_r;
    end
    if (en) begin
      vx11_r   <= vx10_r;
      vy11_r   <= vy10_r;
      t1_11_r  <= t1_10_r;
      p11_r    <= t0_10_r * DIV10_M;
    end
  end

  // final assembly
  logic [TW-1:0]      tmag;
  logic signed [31:0] trs;
  logic               zlin;

  always_comb begin
    tmag   = mode_r ? t1_11_r : TW'(p11_r[TW+28:32]);
    trs    = side11_r.e_neg ? -$signed({9'd0, tmag}) : $signed({9'd0, tmag});
    zlin   = mode_r && side11_r.near;
    tail_v = side11_r.valid;
    if (side11_r.arrived) begin
      tail.arrived = 1'b1;
      tail.vx      = 24'sd0;
      tail.vy      = 24'sd0;
      tail.tr      = 24'sd0;
    end else begin
      tail.arrived = 1'b0;
      tail.vx      = zlin ? 24'sd0 : vx11_r;
      tail.vy      = zlin ? 24'sd0 : vy11_r;
      tail.tr      = sat(trs, max_t_r);
    end
  end

  // output register and skid
  assign take = out_valid_r & !out_stall;

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      out_r <= tail;
    end else if (tail_v) begin
      skid_r <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        skid_full_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= tail_v;
    end else if (tail_v) begin
      skid_full_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_arrived   = out_r.arrived;
  assign out_body_vx   = out_r.vx;
  assign out_body_vy   = out_r.vy;
  assign out_turn_rate = out_r.tr;

  // checks
  logic signed [23:0] lim_t;
  logic               arr_zero;

  assign lim_t    = $signed({1'b0, max_t_r});
  assign arr_zero = (out_body_vx == 24'sd0) && (out_body_vy == 24'sd0) &&
                    (out_turn_rate == 24'sd0);

`include "go_to_pose_velocity_controller_core_assert.svh"

  `GTP_ASSERT_IMP(a_skid_has_out, skid_full_r, out_valid_r, "skid full with empty output")
  `GTP_ASSERT_NXT(a_skid_fill, !skid_full_r && out_valid_r && out_stall && tail_v,
                  skid_full_r, "stalled result was not parked in skid")
  `GTP_ASSERT_IMP(a_arrived_zero, out_valid && out_arrived, arr_zero,
                  "arrived request carries motion")
  `GTP_ASSERT_IMP(a_turn_limit, out_valid, out_turn_rate <= lim_t,
                  "turn rate above limit")

endmodule

`default_nettype wire

// File: sim/tb_go_to_pose_velocity_controller_core.sv
// ----------------------------------------------------------------------------
// tb_go_to_pose_velocity_controller_core
// self-checking bench: drives directed pose requests and random bursts through several
// register settings, predicts each velocity command and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_go_to_pose_velocity_controller_core;
  import gtp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int ROT_STAGES   = 16;

  class pose_scoreboard;
    longint pos_tol, ang_tol, lim_x, lim_y, lim_turn, law;
    res_t   pending_cmds[$];
    int     errors;
    longint rot_atan[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function new();
      pos_tol = 655; ang_tol = 182; lim_x = 65536; lim_y = 65536;
      lim_turn = 262144; law = 0; errors = 0;
    endfunction

    function void set_reg(int idx, longint val);
      case (3'(idx))
        REG_POS_TOL:  pos_tol  = val & 16'hFFFF;
        REG_ANG_TOL:  ang_tol  = val & 15'h7FFF;
        REG_MAX_X:    lim_x    = val & 23'h7FFFFF;
        REG_MAX_Y:    lim_y    = val & 23'h7FFFFF;
        REG_MAX_TURN: lim_turn = val & 23'h7FFFFF;
        REG_MODE:     law      = val & 1;
        default: ;
      endcase
    endfunction

    function longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint div_round(longint n, longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
    endfunction

    function longint clip(longint v, longint l);
      return (v > l) ? l : ((v < -l) ? -l : v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_request(in_t r);
      longint ex, ey, e, d2, x, y, z, xs, ys, bx, by, vx, vy, tr, n2, n64, l2, kn, kd;
      logic signed [15:0] e16;
      logic [15:0] nh;
      logic [31:0] z32;
      logic signed [31:0] zs;
      bit near;
      res_t c;
      ex  = longint'(r.goal_x) - longint'(r.robot_x);
      ey  = longint'(r.goal_y) - longint'(r.robot_y);
      e16 = r.goal_heading - r.robot_heading;
      e   = e16;
      d2  = ex * ex + ey * ey;
      near = d2 < pos_tol * pos_tol;
      c = '0;
      if (near && ((e < 0) ? -e : e) < ang_tol) begin
        c.arrived = 1'b1;
        pending_cmds.push_back(c);
        return;
      end
      // body rotation by minus heading
      x = round_sh(ex * 652032874, 22);
      y = round_sh(ey * 652032874, 22);
      nh = -r.robot_heading;
      z32 = {nh, 16'h0000};
      if (z32[31:30] == 2'd1 || z32[31:30] == 2'd2) begin
        x = -x;
        y = -y;
        z32 = z32 + 32'h80000000;
      end
      zs = z32;
      z = zs;
      for (int i = 0; i < ROT_STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - rot_atan[i];
        end else begin
          x = x + ys; y = y - xs; z = z + rot_atan[i];
        end
      end
      bx = round_sh(x, 8);
      by = round_sh(y, 8);
      if (law == 0) begin
        vx = clip(2 * bx, lim_x);
        vy = clip(2 * by, lim_y);
        kn = 1; kd = 10;
      end else begin
        n2 = bx * bx + by * by;
        if (n2 > 0) begin
          n64 = longint'(int_sqrt(longint'(n2) << 12));
          vx = clip(div_round(bx * 64 * lim_x, n64), lim_x);
          vy = clip(div_round(by * 64 * lim_y, n64), lim_y);
        end else begin
          vx = 0; vy = 0;
        end
        l2 = vx * vx + vy * vy;
        kn = (l2 < 429497) ? 10 : 1;
        kd = 1;
        if (near) begin
          vx = 0; vy = 0;
        end
      end
      tr = clip(div_round(e * 1686629713 * kn, kd << 28), lim_turn);
      c.vx = vx[23:0];
      c.vy = vy[23:0];
      c.tr = tr[23:0];
      pending_cmds.push_back(c);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.arrived !== want.arrived) report_mismatch("arrived", got.arrived, want.arrived);
      if (got.vx !== want.vx) report_mismatch("body_vx", got.vx, want.vx);
      if (got.vy !== want.vy) report_mismatch("body_vy", got.vy, want.vy);
      if (got.tr !== want.tr) report_mismatch("turn_rate", got.tr, want.tr);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_robot_x = '0, in_robot_y = '0, in_goal_x = '0, in_goal_y = '0;
  logic signed [15:0] in_robot_heading = '0, in_goal_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_arrived;
  logic signed [23:0] out_body_vx, out_body_vy, out_turn_rate;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pose_scoreboard sb = new();
  int cycles = 0;
  int stall_phase = 0;

  go_to_pose_velocity_controller_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_robot_x(in_robot_x), .in_robot_y(in_robot_y),
    .in_robot_heading(in_robot_heading),
    .in_goal_x(in_goal_x), .in_goal_y(in_goal_y),
    .in_goal_heading(in_goal_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_arrived(out_arrived), .out_body_vx(out_body_vx),
    .out_body_vy(out_body_vy), .out_turn_rate(out_turn_rate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern: quiet stretches, light and heavy random stretches, periodic stretches
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 600;
    if (stall_phase < 150) begin
      out_stall <= 1'b0;
    end else if (stall_phase < 300) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else if (stall_phase < 450) begin
      out_stall <= ($urandom_range(0, 3) != 0);
    end else begin
      out_stall <= ((stall_phase % 7) < 3);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.arrived = out_arrived;
      got.vx = out_body_vx;
      got.vy = out_body_vy;
      got.tr = out_turn_rate;
      sb.check_result(got);
    end
  end

  task write_reg(int idx, logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 5'(idx * 4); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task drive_request(in_t r);
    in_robot_x = r.robot_x; in_robot_y = r.robot_y;
    in_robot_heading = r.robot_heading;
    in_goal_x = r.goal_x; in_goal_y = r.goal_y;
    in_goal_heading = r.goal_heading;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic in_t pose(int rx, int ry, int rh, int gx, int gy, int gh);
    in_t r;
    r.robot_x = 24'(rx); r.robot_y = 24'(ry); r.robot_heading = 16'(rh);
    r.goal_x = 24'(gx); r.goal_y = 24'(gy); r.goal_heading = 16'(gh);
    return r;
  endfunction

  function automatic in_t random_pose();
    in_t r;
    int k;
    int span;
    r.robot_x = 24'($urandom); r.robot_y = 24'($urandom);
    r.robot_heading = 16'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6) begin
      span = (k < 3) ? 800 : 200000;
      r.goal_x = r.robot_x + 24'($urandom_range(0, 2 * span) - span);
      r.goal_y = r.robot_y + 24'($urandom_range(0, 2 * span) - span);
      r.goal_heading = r.robot_heading + 16'($urandom_range(0, 600) - 300);
    end else begin
      r.goal_x = 24'($urandom); r.goal_y = 24'($urandom);
      r.goal_heading = 16'($urandom);
    end
    return r;
  endfunction

  task run_random(int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 4) == 0) burst = 60;
      for (int i = 0; i < burst && left > 0; i++) begin
        drive_request(random_pose());
        left--;
      end
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed requests at reset settings
    drive_request(pose(0, 0, 0, 0, 0, 0));
    drive_request(pose(100, -100, 50, 150, -50, 100));
    drive_request(pose(-8388608, -8388608, -32768, 8388607, 8388607, 32767));
    drive_request(pose(8388607, 8388607, 32767, -8388608, -8388608, -32768));
    drive_request(pose(0, 0, 16384, 65536, 0, 16384));
    drive_request(pose(0, 0, -16384, 0, 65536, 0));
    drive_request(pose(0, 0, 32767, -65536, 65536, -32768));
    drive_request(pose(0, 0, 0, 0, 0, 1000));
    drive_request(pose(5, 5, 0, 5, 5, -32768));
    drive_request(pose(0, 0, 8192, 654, 0, 181));
    wait_drained();

    // constant speed law with tiny and large errors
    write_reg(REG_MODE, 32'd1);
    drive_request(pose(0, 0, 0, 1, 0, 5000));
    drive_request(pose(0, 0, 0, 0, 0, 5000));
    drive_request(pose(0, 0, 12345, 300, 200, -5000));
    drive_request(pose(0, 0, -20000, 8388607, -8388608, 0));
    drive_request(pose(1000, 2000, 0, 700000, -300000, 10));
    run_random(150);

    // widest settings, unused register address ignored
    write_reg(REG_POS_TOL, 32'd65535);
    write_reg(REG_ANG_TOL, 32'd32767);
    write_reg(REG_MAX_X, 32'd8388607);
    write_reg(REG_MAX_Y, 32'd8388607);
    write_reg(REG_MAX_TURN, 32'd8388607);
    write_reg(REG_MODE, 32'd0);
    write_reg(6, 32'hFFFFFFFF);
    drive_request(pose(-8388608, 0, 0, 8388607, 0, 32767));
    run_random(150);
    write_reg(REG_MODE, 32'd1);
    run_random(120);

    // zero tolerances and zero limits
    write_reg(REG_POS_TOL, 32'd0);
    write_reg(REG_ANG_TOL, 32'd0);
    write_reg(REG_MAX_X, 32'd0);
    write_reg(REG_MAX_Y, 32'd0);
    write_reg(REG_MAX_TURN, 32'd0);
    drive_request(pose(0, 0, 0, 0, 0, 0));
    drive_request(pose(0, 0, 0, 90000, -90000, 900));
    run_random(60);
    write_reg(REG_MODE, 32'd0);
    run_random(60);

    // random settings
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_POS_TOL, $urandom_range(0, 65535));
      write_reg(REG_ANG_TOL, $urandom_range(0, 32767));
      write_reg(REG_MAX_X, $urandom_range(0, 8388607));
      write_reg(REG_MAX_Y, $urandom_range(0, 300000));
      write_reg(REG_MAX_TURN, $urandom_range(0, 8388607));
      write_reg(REG_MODE, p % 2);
      run_random(85);
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
